FILE: src/lsdf_pkg.sv
// ----------------------------------------------------------------------------
// lsdf_pkg
// Shared constants of the LED shadow register with dirty flush.
// ----------------------------------------------------------------------------
package lsdf_pkg;

  // payload widths
  localparam int unsigned LED_IDX_W  = 8;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned OUT_ADDR_W = 5;
  localparam int unsigned BIT_SEL_W  = 3;
  localparam int unsigned BYTE_ID_W  = LED_IDX_W - BIT_SEL_W;

  // latch address is byte index plus this offset, wrapped
  localparam int unsigned ADDR_OFFSET = 7;

  // request codes on the mode field
  localparam logic MODE_SET   = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

endpackage

FILE: src/led_shadow_dirty_flush.sv
// ----------------------------------------------------------------------------
// led_shadow_dirty_flush
// Shadow copy of the LED latch bytes with per-byte dirty flags and flush.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o) carries set and flush requests.
// A set request with mode_i low updates one LED bit in the shadow memory and
// marks its byte dirty; it produces no output. It is a read-modify-write on
// the byte memory: the read is issued when the set is accepted, and the input
// is held off during the write state. A set whose byte index is NUM_LATCHES
// or higher is accepted and dropped. A flush request with mode_i high walks
// the dirty bytes from the lowest index up and sends one latch write per
// dirty byte on the output channel (out_valid_o / out_ready_i), with
// last_write_o on the final one. Each byte passes through the memory read
// register and then the output register; writes follow at one per cycle
// while the receiver takes them; the single read port of the byte memory
// sets that rate. Input is held off until the last read has moved into the
// output register; when no byte is dirty, the flush returns straight to idle.
// A receiver stall holds the output register and pauses the memory reads.
// Reset makes every shadow byte read as zero (per-entry valid bits) and
// marks every byte dirty, so the first flush writes all latches.
// ----------------------------------------------------------------------------
module led_shadow_dirty_flush #(
  parameter int unsigned NUM_LATCHES = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               mode_i,
  input  logic [lsdf_pkg::LED_IDX_W-1:0]     led_index_i,
  input  logic                               led_on_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [lsdf_pkg::OUT_ADDR_W-1:0]    latch_address_o,
  output logic [lsdf_pkg::BYTE_W-1:0]        latch_data_o,
  output logic                               last_write_o
);
  import lsdf_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_LATCHES);
  localparam int unsigned OFFS  = ADDR_OFFSET % NUM_LATCHES;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SET_WR,
    ST_FLUSH
  } state_e;

  state_e                  state_q;
  logic [NUM_LATCHES-1:0]  dirty_q;
  logic [NUM_LATCHES-1:0]  rem_q;
  logic [NUM_LATCHES-1:0]  byte_vld_q;
  logic [IDX_W-1:0]        set_idx_q;
  logic [BIT_SEL_W-1:0]    set_bit_q;
  logic                    set_on_q;

  // byte memory and its registered read port
  logic [BYTE_W-1:0]       mem_q [NUM_LATCHES];
  logic [BYTE_W-1:0]       rd_data_q;
  logic                    rd_vld_q;
  logic                    rd_pend_q;
  logic [OUT_ADDR_W-1:0]   rd_addr_q;
  logic                    rd_last_q;

  logic                    out_valid_q;
  logic [OUT_ADDR_W-1:0]   out_addr_q;
  logic [BYTE_W-1:0]       out_data_q;
  logic                    out_last_q;

  logic                    in_fire;
  logic [BYTE_ID_W-1:0]    in_byte;
  logic                    in_byte_ok;
  logic                    set_go;
  logic                    load_out;
  logic                    issue;
  logic [NUM_LATCHES-1:0]  low_bit;
  logic [IDX_W-1:0]        pick_idx;
  logic                    pick_last;
  logic [IDX_W:0]          addr_sum;
  logic [IDX_W:0]          addr_wrap;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_idx;
  logic [BYTE_W-1:0]       rd_byte;
  logic [BYTE_W-1:0]       wr_byte;
  logic                    wr_en;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_byte    = led_index_i[LED_IDX_W-1:BIT_SEL_W];
  assign in_byte_ok = ({1'b0, in_byte} < (BYTE_ID_W + 1)'(NUM_LATCHES));
  assign set_go     = in_fire && (mode_i == MODE_SET) && in_byte_ok;

  // output register takes read data when free or being drained
  assign load_out = rd_pend_q && (!out_valid_q || out_ready_i);

  // lowest remaining dirty byte
  assign low_bit   = rem_q & (~rem_q + 1'b1);
  assign pick_last = ((rem_q & ~low_bit) == '0);
  always_comb begin
    pick_idx = '0;
    for (int k = 0; k < NUM_LATCHES; k++) begin
      if (low_bit[k]) begin
        pick_idx = pick_idx | IDX_W'(k);
      end
    end
  end

  assign issue = (state_q == ST_FLUSH) && (rem_q != '0) && (!rd_pend_q || load_out);

  // latch address: index plus offset, wrapped once
  assign addr_sum  = {1'b0, pick_idx} + (IDX_W + 1)'(OFFS);
  assign addr_wrap = (addr_sum >= (IDX_W + 1)'(NUM_LATCHES))
                   ? addr_sum - (IDX_W + 1)'(NUM_LATCHES) : addr_sum;

  // shared read port
  assign rd_en  = set_go || issue;
  assign rd_idx = set_go ? in_byte[IDX_W-1:0] : pick_idx;

  // modify step of a set request
  assign rd_byte = rd_vld_q ? rd_data_q : '0;
  always_comb begin
    wr_byte = rd_byte;
    wr_byte[set_bit_q] = set_on_q;
  end
  assign wr_en = (state_q == ST_SET_WR);

  // byte memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[set_idx_q] <= wr_byte;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_idx];
    end
  end

  // control, flags and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dirty_q     <= '1;
      rem_q       <= '0;
      byte_vld_q  <= '0;
      rd_vld_q    <= 1'b0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_q <= byte_vld_q[rd_idx];
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (issue) begin
        rd_pend_q <= 1'b1;
      end else if (load_out) begin
        rd_pend_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (set_go) begin
            state_q <= ST_SET_WR;
          end else if (in_fire && (mode_i == MODE_FLUSH)) begin
            rem_q   <= dirty_q;
            dirty_q <= '0;
            state_q <= ST_FLUSH;
          end
        end
        ST_SET_WR: begin
          byte_vld_q[set_idx_q] <= 1'b1;
          dirty_q[set_idx_q]    <= 1'b1;
          state_q               <= ST_IDLE;
        end
        ST_FLUSH: begin
          if (issue) begin
            rem_q <= rem_q & ~low_bit;
          end else if ((rem_q == '0) && !rd_pend_q) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // request and read payload registers
  always_ff @(posedge clk_i) begin
    if (set_go) begin
      set_idx_q <= in_byte[IDX_W-1:0];
      set_bit_q <= led_index_i[BIT_SEL_W-1:0];
      set_on_q  <= led_on_i;
    end
    if (issue) begin
      rd_addr_q <= OUT_ADDR_W'(addr_wrap[IDX_W-1:0]);
      rd_last_q <= pick_last;
    end
    if (load_out) begin
      out_addr_q <= rd_addr_q;
      out_data_q <= rd_byte;
      out_last_q <= rd_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign latch_address_o = out_addr_q;
  assign latch_data_o    = out_data_q;
  assign last_write_o    = out_last_q;

endmodule

FILE: src/lsdf_checker.sv
// ----------------------------------------------------------------------------
// lsdf_checker
// Port-level checks for the LED shadow register with dirty flush.
// ----------------------------------------------------------------------------
module lsdf_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               mode_i,
  input logic [lsdf_pkg::LED_IDX_W-1:0]     led_index_i,
  input logic                               led_on_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [lsdf_pkg::OUT_ADDR_W-1:0]    latch_address_o,
  input logic [lsdf_pkg::BYTE_W-1:0]        latch_data_o,
  input logic                               last_write_o
);
  import lsdf_pkg::*;

  // a stalled write keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(latch_address_o)
      && $stable(latch_data_o) && $stable(last_write_o))
    else $error("stalled latch write changed");

  // a flush request holds off the next request
  a_flush_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == MODE_FLUSH) |=> !in_ready_o)
    else $error("input ready right after flush request");

  // a set request never starts a latch write
  a_set_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == MODE_SET) |=> !$rose(out_valid_o))
    else $error("set request produced a latch write");

  // latch writes appear only after a flush is taken
  a_out_from_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("latch write without flush in progress");

endmodule

bind led_shadow_dirty_flush lsdf_checker u_lsdf_checker (.*);
